@@ rtl/pn2d_pkg.sv @@
// ----------------------------------------------------------------------------
// pn2d_pkg: shared types, constants and helpers for the 2D noise unit
// Holds the fixed-point constants, rounding helpers and the gradient
// selection used by the noise pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package pn2d_pkg;

    // Fixed-point format of coordinates and results.
    localparam int FRAC_BITS = 16;
    localparam int TBL_AW    = 8;

    // Request function codes.
    localparam logic FUNC_EVAL  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // Gradient direction codes taken from hash bits 2..0.
    localparam logic [2:0] GRAD_XPY  = 3'd0;
    localparam logic [2:0] GRAD_X    = 3'd1;
    localparam logic [2:0] GRAD_XMY  = 3'd2;
    localparam logic [2:0] GRAD_NY   = 3'd3;
    localparam logic [2:0] GRAD_NXNY = 3'd4;
    localparam logic [2:0] GRAD_NX   = 3'd5;
    localparam logic [2:0] GRAD_NXPY = 3'd6;
    localparam logic [2:0] GRAD_Y    = 3'd7;

    // Fade polynomial constants in the fixed-point scale.
    localparam logic [19:0] FADE_C15 = 20'(15 << FRAC_BITS);
    localparam logic [20:0] FADE_C10 = 21'(10 << FRAC_BITS);
    localparam logic [35:0] HALF_U   = 36'(1 << (FRAC_BITS - 1));
    localparam logic signed [39:0] HALF_S = 40'sd32768;

    // Saturation limit of the result, 2.0 in the fixed-point scale.
    localparam logic signed [23:0] LIM_POS = 24'sd131072;
    localparam logic signed [23:0] LIM_NEG = -24'sd131072;

    typedef logic [TBL_AW-1:0] tbl_addr_t;
    typedef logic [7:0]        tbl_data_t;

    // Round to nearest for an unsigned product.
    function automatic logic [20:0] rnd_u(input logic [35:0] m);
        logic [35:0] t;
        begin
            t = m + HALF_U;
            return t[36-1:FRAC_BITS] > 0 ? 21'(t >> FRAC_BITS) : 21'd0;
        end
    endfunction

    // Round to nearest, ties upward, for a signed product.
    function automatic logic signed [23:0] rnd_s(input logic signed [39:0] p);
        logic signed [39:0] t;
        begin
            t = p + HALF_S;
            return 24'(t >>> FRAC_BITS);
        end
    endfunction

    // Dot product of a corner offset with the gradient picked by the hash.
    function automatic logic signed [18:0] grad(
        input logic [2:0]         h,
        input logic signed [17:0] dx,
        input logic signed [17:0] dy
    );
        logic signed [18:0] ex;
        logic signed [18:0] ey;
        begin
            ex = 19'(dx);
            ey = 19'(dy);
            case (h)
                GRAD_XPY:  return ex + ey;
                GRAD_X:    return ex;
                GRAD_XMY:  return ex - ey;
                GRAD_NY:   return -ey;
                GRAD_NXNY: return -ex - ey;
                GRAD_NX:   return -ex;
                GRAD_NXPY: return ey - ex;
                default:   return ey;
            endcase
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/pn2d_ram.sv @@
// ----------------------------------------------------------------------------
// pn2d_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pn2d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/perlin_noise_2d_unit.sv @@
// ----------------------------------------------------------------------------
// perlin_noise_2d_unit: pipelined 2D gradient noise evaluator
// Hashes lattice corners through a loaded permutation table, fades the
// fractional offsets and blends the four corner gradients.
// ----------------------------------------------------------------------------
// The unit takes one request per clock while the result register is not
// stalled. A noise result passes through the eight register stages of
// table lookup, fade and blend arithmetic before it is taken from the
// result register, the last of the eight. A write
// request loads one permutation table entry and returns nothing; the table
// has to be loaded before any evaluation reads it. The table is kept in six
// copies, two for the cell hash and four for the corner hash, so that every
// point reads both cell entries together and all four corner entries together
// at the following stage; each write travels down the pipeline to keep the
// copies in request order. When the result register is stalled the whole
// pipeline holds.
`default_nettype none

module perlin_noise_2d_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire logic               func,
    input  wire logic [23:0]        x_coord,
    input  wire logic [23:0]        y_coord,
    input  wire logic [7:0]         entry_index,
    input  wire logic [7:0]         entry_value,
    output logic                    res_valid,
    input  wire logic               res_stall,
    output logic signed [18:0]      noise_value
);

    localparam int F = pn2d_pkg::FRAC_BITS;

    logic adv;
    logic accept;

    // Stage valid bits.
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg;
    logic s5_vld_reg, s6_vld_reg, s7_vld_reg, out_vld_reg;
    logic s1_wr_reg;

    // Stage payloads.
    logic [7:0]         s1_idx_reg, s1_val_reg;
    logic [7:0]         s1_cy_reg;
    logic [F-1:0]       s1_fx_reg, s1_fy_reg, s2_fx_reg, s2_fy_reg;
    logic [F-1:0]       s3_fx_reg, s3_fy_reg;
    logic [35:0]        s1_mx_reg, s1_my_reg, s2_mx_reg, s2_my_reg;
    logic [35:0]        s3_mx_reg, s3_my_reg, s4_mx_reg, s4_my_reg;
    logic signed [18:0] s3_ga_reg, s3_gb_reg, s3_gc_reg, s3_gd_reg;
    logic signed [18:0] s4_ga_reg, s4_gb_reg, s4_gc_reg, s4_gd_reg;
    logic signed [18:0] s5_ga_reg, s5_gc_reg;
    logic signed [37:0] s5_p1_reg, s5_p2_reg;
    logic [16:0]        s5_v_reg, s6_v_reg;
    logic signed [20:0] s6_x1_reg, s6_x2_reg, s7_x1_reg;
    logic signed [39:0] s7_pr_reg;
    logic signed [18:0] out_noise_reg;

    // Table read data.
    logic [7:0] pa, pb, haa, hab, hba, hbb;

    // Handshake: the pipeline advances unless a finished result is stalled.
    assign adv       = !(out_vld_reg && res_stall);
    assign req_stall = !adv;
    assign accept    = req_valid && adv;
    assign res_valid = out_vld_reg;
    assign noise_value = out_noise_reg;

    // Cell hash tables, written on accept and read with the request.
    logic [7:0] cx, cx1;
    logic       wr_a, wr_b;
    assign cx   = x_coord[F +: 8];
    assign cx1  = cx + 8'd1;
    assign wr_a = accept && (func == pn2d_pkg::FUNC_WRITE);
    assign wr_b = adv && s1_wr_reg;

    pn2d_ram #(.WIDTH(8), .DEPTH(256)) u_ram_pa (
        .clk(clk), .we(wr_a), .waddr(entry_index), .wdata(entry_value),
        .re(adv), .raddr(cx), .rdata(pa)
    );
    pn2d_ram #(.WIDTH(8), .DEPTH(256)) u_ram_pb (
        .clk(clk), .we(wr_a), .waddr(entry_index), .wdata(entry_value),
        .re(adv), .raddr(cx1), .rdata(pb)
    );

    // Corner hash tables, written one stage later to keep request order.
    logic [7:0] a_aa, a_ab, a_ba, a_bb;
    assign a_aa = pa + s1_cy_reg;
    assign a_ab = pa + s1_cy_reg + 8'd1;
    assign a_ba = pb + s1_cy_reg;
    assign a_bb = pb + s1_cy_reg + 8'd1;

    pn2d_ram #(.WIDTH(8), .DEPTH(256)) u_ram_aa (
        .clk(clk), .we(wr_b), .waddr(s1_idx_reg), .wdata(s1_val_reg),
        .re(adv), .raddr(a_aa), .rdata(haa)
    );
    pn2d_ram #(.WIDTH(8), .DEPTH(256)) u_ram_ab (
        .clk(clk), .we(wr_b), .waddr(s1_idx_reg), .wdata(s1_val_reg),
        .re(adv), .raddr(a_ab), .rdata(hab)
    );
    pn2d_ram #(.WIDTH(8), .DEPTH(256)) u_ram_ba (
        .clk(clk), .we(wr_b), .waddr(s1_idx_reg), .wdata(s1_val_reg),
        .re(adv), .raddr(a_ba), .rdata(hba)
    );
    pn2d_ram #(.WIDTH(8), .DEPTH(256)) u_ram_bb (
        .clk(clk), .we(wr_b), .waddr(s1_idx_reg), .wdata(s1_val_reg),
        .re(adv), .raddr(a_bb), .rdata(hbb)
    );

    // Stage 1 math: first fade product f * (15 - 6f).
    logic [F-1:0] fx_in, fy_in;
    logic [19:0]  tx, ty;
    logic [35:0]  m0x_next, m0y_next;
    assign fx_in    = x_coord[F-1:0];
    assign fy_in    = y_coord[F-1:0];
    assign tx       = pn2d_pkg::FADE_C15 - ((20'(fx_in) << 2) + (20'(fx_in) << 1));
    assign ty       = pn2d_pkg::FADE_C15 - ((20'(fy_in) << 2) + (20'(fy_in) << 1));
    assign m0x_next = 36'(fx_in) * 36'(tx);
    assign m0y_next = 36'(fy_in) * 36'(ty);

    // Stage 2 math: f * (10 - previous term).
    logic [19:0] gx, gy;
    logic [35:0] m1x_next, m1y_next;
    assign gx       = 20'(pn2d_pkg::FADE_C10 - pn2d_pkg::rnd_u(s1_mx_reg));
    assign gy       = 20'(pn2d_pkg::FADE_C10 - pn2d_pkg::rnd_u(s1_my_reg));
    assign m1x_next = 36'(s1_fx_reg) * 36'(gx);
    assign m1y_next = 36'(s1_fy_reg) * 36'(gy);

    // Stage 3 math: next fade product and the four corner gradients.
    logic [35:0]        m2x_next, m2y_next;
    logic signed [17:0] dx0, dx1, dy0, dy1;
    assign m2x_next = 36'(s2_fx_reg) * 36'(pn2d_pkg::rnd_u(s2_mx_reg));
    assign m2y_next = 36'(s2_fy_reg) * 36'(pn2d_pkg::rnd_u(s2_my_reg));
    assign dx0 = $signed({2'b00, s2_fx_reg});
    assign dx1 = $signed({2'b11, s2_fx_reg});
    assign dy0 = $signed({2'b00, s2_fy_reg});
    assign dy1 = $signed({2'b11, s2_fy_reg});

    // Stage 4 math: last fade product.
    logic [35:0] m3x_next, m3y_next;
    assign m3x_next = 36'(s3_fx_reg) * 36'(pn2d_pkg::rnd_u(s3_mx_reg));
    assign m3y_next = 36'(s3_fy_reg) * 36'(pn2d_pkg::rnd_u(s3_my_reg));

    // Stage 5 math: fade results and the two x-direction blend products.
    logic [16:0]        u_fade, v_fade;
    logic signed [17:0] u_s;
    logic signed [19:0] d1, d2;
    assign u_fade = 17'(pn2d_pkg::rnd_u(s4_mx_reg));
    assign v_fade = 17'(pn2d_pkg::rnd_u(s4_my_reg));
    assign u_s    = $signed({1'b0, u_fade});
    assign d1     = 20'(s4_gb_reg) - 20'(s4_ga_reg);
    assign d2     = 20'(s4_gd_reg) - 20'(s4_gc_reg);

    // Stage 6 math: finish the x-direction blends.
    logic signed [20:0] x1_next, x2_next;
    assign x1_next = 21'(24'(s5_ga_reg) + pn2d_pkg::rnd_s(40'(s5_p1_reg)));
    assign x2_next = 21'(24'(s5_gc_reg) + pn2d_pkg::rnd_s(40'(s5_p2_reg)));

    // Stage 7 math: y-direction blend product.
    logic signed [17:0] v_s;
    logic signed [21:0] d3;
    assign v_s = $signed({1'b0, s6_v_reg});
    assign d3  = 22'(s6_x2_reg) - 22'(s6_x1_reg);

    // Output math: finish the blend and saturate to plus or minus 2.0.
    logic signed [23:0] r_sum;
    logic signed [18:0] noise_next;
    assign r_sum = 24'(s7_x1_reg) + pn2d_pkg::rnd_s(s7_pr_reg);
    always_comb
    begin
        if (r_sum > pn2d_pkg::LIM_POS)
        begin
            noise_next = 19'(pn2d_pkg::LIM_POS);
        end
        else if (r_sum < pn2d_pkg::LIM_NEG)
        begin
            noise_next = 19'(pn2d_pkg::LIM_NEG);
        end
        else
        begin
            noise_next = 19'(r_sum);
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s1_wr_reg   <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            s6_vld_reg  <= 1'b0;
            s7_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg  <= accept && (func == pn2d_pkg::FUNC_EVAL);
            s1_wr_reg   <= wr_a;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            s4_vld_reg  <= s3_vld_reg;
            s5_vld_reg  <= s4_vld_reg;
            s6_vld_reg  <= s5_vld_reg;
            s7_vld_reg  <= s6_vld_reg;
            out_vld_reg <= s7_vld_reg;
        end
    end

    // Pipeline data registers.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_idx_reg <= entry_index;
            s1_val_reg <= entry_value;
            s1_cy_reg  <= y_coord[F +: 8];
            s1_fx_reg  <= fx_in;
            s1_fy_reg  <= fy_in;
            s1_mx_reg  <= m0x_next;
            s1_my_reg  <= m0y_next;

            s2_fx_reg  <= s1_fx_reg;
            s2_fy_reg  <= s1_fy_reg;
            s2_mx_reg  <= m1x_next;
            s2_my_reg  <= m1y_next;

            s3_fx_reg  <= s2_fx_reg;
            s3_fy_reg  <= s2_fy_reg;
            s3_mx_reg  <= m2x_next;
            s3_my_reg  <= m2y_next;
            s3_ga_reg  <= pn2d_pkg::grad(haa[2:0], dx0, dy0);
            s3_gb_reg  <= pn2d_pkg::grad(hba[2:0], dx1, dy0);
            s3_gc_reg  <= pn2d_pkg::grad(hab[2:0], dx0, dy1);
            s3_gd_reg  <= pn2d_pkg::grad(hbb[2:0], dx1, dy1);

            s4_mx_reg  <= m3x_next;
            s4_my_reg  <= m3y_next;
            s4_ga_reg  <= s3_ga_reg;
            s4_gb_reg  <= s3_gb_reg;
            s4_gc_reg  <= s3_gc_reg;
            s4_gd_reg  <= s3_gd_reg;

            s5_v_reg   <= v_fade;
            s5_ga_reg  <= s4_ga_reg;
            s5_gc_reg  <= s4_gc_reg;
            s5_p1_reg  <= 38'(u_s) * 38'(d1);
            s5_p2_reg  <= 38'(u_s) * 38'(d2);

            s6_v_reg   <= s5_v_reg;
            s6_x1_reg  <= x1_next;
            s6_x2_reg  <= x2_next;

            s7_x1_reg  <= s6_x1_reg;
            s7_pr_reg  <= 40'(v_s) * 40'(d3);

            out_noise_reg <= noise_next;
        end
    end

`ifndef SYNTH
    // The request side stalls exactly when a finished result is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_stall == (res_valid && res_stall))
        else $error("request stall does not follow the result register");

    // A result never leaves the saturation range.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (noise_value <= 19'sd131072 && noise_value >= -19'sd131072))
        else $error("noise result outside plus or minus 2.0");

    // A write request never produces a result one stage later.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && func == pn2d_pkg::FUNC_WRITE) |=> !s1_vld_reg)
        else $error("write request entered the evaluation pipeline");

    // The last stage moves into the result register when not stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s7_vld_reg && !req_stall) |=> res_valid)
        else $error("evaluated point lost before the result register");
`endif

endmodule

`default_nettype wire
